FILE: hdl/lms_pkg.sv
// Shared types, constants and the sequencer microcode for the LED matrix frame scanner.
package lms_pkg;

    localparam int LMS_NUM_COLUMNS   = 60;
    localparam int LMS_NUM_ROWS      = 7;
    localparam int LMS_COLS_PER_BANK = 15;
    localparam int LMS_NUM_BANKS     = 4;
    localparam int LMS_ROW_W         = 7;
    localparam int LMS_HOLD_W        = 16;
    localparam int LMS_PADDR_W       = 4;
    localparam int LMS_PDATA_W       = 32;
    localparam int LMS_UPC_W         = 4;
    localparam int LMS_INIT_WORDS    = 16;

    localparam logic [LMS_HOLD_W-1:0] LMS_STROBE_RESET = 16'd500;

    // decoder lines: banks start at 2, latches at 6
    localparam logic [2:0] LMS_SEL_BANK0  = 3'd2;
    localparam logic [2:0] LMS_SEL_LATCH0 = 3'd6;

    typedef enum logic [1:0] {
        REG_ROTATION    = 2'd0,
        REG_AUTO_UPDATE = 2'd1,
        REG_STROBE_HOLD = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        CMD_PIXEL  = 3'd0,
        CMD_COLUMN = 3'd1,
        CMD_CLEAR  = 3'd2,
        CMD_SCAN   = 3'd3,
        CMD_INIT   = 3'd4
    } t_cmd;

    typedef struct packed {
        logic [1:0]            rotation;
        logic                  auto_update;
        logic [LMS_HOLD_W-1:0] strobe_hold;
    } t_cfg;

    typedef enum logic [3:0] {
        ACT_FETCH,
        ACT_NONE,
        ACT_PIX_RD,
        ACT_PIX_WR,
        ACT_COL_WR,
        ACT_CLEAR,
        ACT_COPY_RD,
        ACT_COPY_WR,
        ACT_BANK_RD,
        ACT_BANK_EMIT,
        ACT_EN_EMIT,
        ACT_DIS_EMIT,
        ACT_INIT_EMIT
    } t_act;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_GOTO,
        COND_DISPATCH,
        COND_NO_COPY,
        COND_COPY_MORE,
        COND_BANK_MORE,
        COND_INIT_MORE
    } t_cond;

    typedef struct packed {
        t_act                 act;
        t_cond                cond;
        logic [LMS_UPC_W-1:0] target;
    } t_uword;

    localparam logic [LMS_UPC_W-1:0] UPC_FETCH     = 4'd0;
    localparam logic [LMS_UPC_W-1:0] UPC_PIX_RD    = 4'd1;
    localparam logic [LMS_UPC_W-1:0] UPC_PIX_WR    = 4'd2;
    localparam logic [LMS_UPC_W-1:0] UPC_COL_WR    = 4'd3;
    localparam logic [LMS_UPC_W-1:0] UPC_CLEAR     = 4'd4;
    localparam logic [LMS_UPC_W-1:0] UPC_SCAN      = 4'd5;
    localparam logic [LMS_UPC_W-1:0] UPC_COPY_RD   = 4'd6;
    localparam logic [LMS_UPC_W-1:0] UPC_COPY_WR   = 4'd7;
    localparam logic [LMS_UPC_W-1:0] UPC_BANK_RD   = 4'd8;
    localparam logic [LMS_UPC_W-1:0] UPC_BANK_EMIT = 4'd9;
    localparam logic [LMS_UPC_W-1:0] UPC_EN        = 4'd10;
    localparam logic [LMS_UPC_W-1:0] UPC_DIS       = 4'd11;
    localparam logic [LMS_UPC_W-1:0] UPC_INIT      = 4'd12;
    localparam logic [LMS_UPC_W-1:0] UPC_RET       = 4'd13;

    function automatic t_uword lms_ucode(input logic [LMS_UPC_W-1:0] upc);
        t_uword w;
        w = '{act: ACT_NONE, cond: COND_GOTO, target: UPC_FETCH};
        unique case (upc)
            UPC_FETCH:     w = '{act: ACT_FETCH,     cond: COND_DISPATCH,  target: UPC_FETCH};
            UPC_PIX_RD:    w = '{act: ACT_PIX_RD,    cond: COND_NEXT,      target: UPC_FETCH};
            UPC_PIX_WR:    w = '{act: ACT_PIX_WR,    cond: COND_GOTO,      target: UPC_FETCH};
            UPC_COL_WR:    w = '{act: ACT_COL_WR,    cond: COND_GOTO,      target: UPC_FETCH};
            UPC_CLEAR:     w = '{act: ACT_CLEAR,     cond: COND_GOTO,      target: UPC_FETCH};
            UPC_SCAN:      w = '{act: ACT_NONE,      cond: COND_NO_COPY,   target: UPC_BANK_RD};
            UPC_COPY_RD:   w = '{act: ACT_COPY_RD,   cond: COND_NEXT,      target: UPC_FETCH};
            UPC_COPY_WR:   w = '{act: ACT_COPY_WR,   cond: COND_COPY_MORE, target: UPC_COPY_RD};
            UPC_BANK_RD:   w = '{act: ACT_BANK_RD,   cond: COND_NEXT,      target: UPC_FETCH};
            UPC_BANK_EMIT: w = '{act: ACT_BANK_EMIT, cond: COND_BANK_MORE, target: UPC_BANK_RD};
            UPC_EN:        w = '{act: ACT_EN_EMIT,   cond: COND_NEXT,      target: UPC_FETCH};
            UPC_DIS:       w = '{act: ACT_DIS_EMIT,  cond: COND_GOTO,      target: UPC_FETCH};
            UPC_INIT:      w = '{act: ACT_INIT_EMIT, cond: COND_INIT_MORE, target: UPC_INIT};
            UPC_RET:       w = '{act: ACT_NONE,      cond: COND_GOTO,      target: UPC_FETCH};
            default:       w = '{act: ACT_NONE,      cond: COND_GOTO,      target: UPC_FETCH};
        endcase
        return w;
    endfunction

    function automatic logic [LMS_UPC_W-1:0] lms_dispatch(input logic [2:0] cmd);
        logic [LMS_UPC_W-1:0] upc;
        upc = UPC_FETCH;
        unique case (cmd)
            CMD_PIXEL:  upc = UPC_PIX_RD;
            CMD_COLUMN: upc = UPC_COL_WR;
            CMD_CLEAR:  upc = UPC_CLEAR;
            CMD_SCAN:   upc = UPC_SCAN;
            CMD_INIT:   upc = UPC_INIT;
            default:    upc = UPC_FETCH;
        endcase
        return upc;
    endfunction

endpackage

FILE: hdl/led_matrix_frame_scanner_top.sv
// Top level: microcoded frame store and scan sequencer for the LED matrix sign.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+---------------------------------------------
//  command  | in        | i_valid / o_ready   | i_cmd i_pos_x i_pos_y i_color i_column_value
//  bus word | out       | o_valid / i_ready   | o_select_line o_bank_data o_latch_idx
//           |           |                     | o_latch_value o_hold_ticks o_last
//  config   | in        | psel/penable/pready | paddr pwdata prdata (APB)
//
// A command word is taken in the fetch step; pixel reads then writes the draw store, column write and
// clear act on it directly, and the scan and initialise emit steps hold on any output stalls.
// A scan at frame start with auto update first copies the draw store to the shown store: each entry
// is read and then written, through the single read port of the draw store.
// Reset is synchronous; all stores read as zero after reset with no clearing pass.
// A stalled output word holds the step counter on its emit step.
module led_matrix_frame_scanner_top
    import lms_pkg::*;
#(
    parameter int NUM_COLUMNS = LMS_NUM_COLUMNS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [2:0]             i_cmd,
    input  logic signed [7:0]      i_pos_x,
    input  logic signed [7:0]      i_pos_y,
    input  logic                   i_color,
    input  logic [7:0]             i_column_value,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [2:0]             o_select_line,
    output logic [LMS_ROW_W-1:0]   o_bank_data,
    output logic [2:0]             o_latch_idx,
    output logic                   o_latch_value,
    output logic [LMS_HOLD_W-1:0]  o_hold_ticks,
    output logic                   o_last,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [LMS_PADDR_W-1:0] paddr,
    input  logic [LMS_PDATA_W-1:0] pwdata,
    output logic [LMS_PDATA_W-1:0] prdata,
    output logic                   pready
);

    localparam int AW  = $clog2(NUM_COLUMNS);
    localparam int IW  = (AW > 4) ? AW : 4;
    localparam int BAW = (AW + 1 > 6) ? AW + 1 : 6;
    localparam logic signed [9:0] NCS  = 10'(NUM_COLUMNS);
    localparam logic signed [9:0] NCM1 = 10'(NUM_COLUMNS - 1);
    localparam logic signed [9:0] NRS  = 10'(LMS_NUM_ROWS);
    localparam logic signed [9:0] NRM1 = 10'(LMS_NUM_ROWS - 1);

    t_cfg cfg;

    lms_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencer state
    logic [LMS_UPC_W-1:0] r_upc, n_upc;
    logic [IW-1:0]        r_idx;
    logic [1:0]           r_bank;
    logic [3:0]           r_scan_col;
    logic                 r_shown_ok;

    // captured command word
    logic signed [7:0]    r_pos_x, r_pos_y;
    logic                 r_color;
    logic [7:0]           r_column_value;

    // stores
    logic [LMS_ROW_W-1:0] r_draw_mem  [NUM_COLUMNS];
    logic [LMS_ROW_W-1:0] r_shown_mem [NUM_COLUMNS];
    logic [NUM_COLUMNS-1:0] r_draw_vld;
    logic [LMS_ROW_W-1:0] r_draw_q, r_shown_q;
    logic                 r_draw_vq, r_bank_ok;

    // output register
    logic                  r_o_valid;
    logic [2:0]            r_o_sel;
    logic [LMS_ROW_W-1:0]  r_o_data;
    logic [2:0]            r_o_bit;
    logic                  r_o_val;
    logic [LMS_HOLD_W-1:0] r_o_hold;
    logic                  r_o_last;

    t_uword               uw;
    logic                 is_emit, go, take, accept;
    logic signed [9:0]    sx, sy, px, py;
    logic                 pix_ok, col_ok;
    logic [LMS_ROW_W-1:0] draw_old, pix_mask, pix_new;
    logic [BAW-1:0]       baddr;
    logic                 baddr_ok;
    logic [4:0]           col_inc;
    logic                 draw_rd_en, draw_wr_en, shown_wr_en;
    logic [AW-1:0]        draw_rd_addr, draw_wr_addr;
    logic [LMS_ROW_W-1:0] draw_wr_data;

    assign uw      = lms_ucode(r_upc);
    assign o_ready = (uw.act == ACT_FETCH);
    assign accept  = i_valid & o_ready;
    assign is_emit = (uw.act == ACT_BANK_EMIT) || (uw.act == ACT_EN_EMIT) ||
                     (uw.act == ACT_DIS_EMIT) || (uw.act == ACT_INIT_EMIT);
    // hold the step on a full output register or an empty input
    assign go      = !(is_emit && r_o_valid && !i_ready) && !(o_ready && !i_valid);

    // pixel rotation
    always_comb begin
        sx = {{2{r_pos_x[7]}}, r_pos_x};
        sy = {{2{r_pos_y[7]}}, r_pos_y};
        unique case (cfg.rotation)
            2'd1: begin
                px = NCM1 - sy;
                py = sx;
            end
            2'd2: begin
                px = NCM1 - sx;
                py = NRM1 - sy;
            end
            2'd3: begin
                px = sy;
                py = NRM1 - sx;
            end
            default: begin
                px = sx;
                py = sy;
            end
        endcase
        pix_ok   = !px[9] && (px < NCS) && !py[9] && (py < NRS);
        col_ok   = !sx[9] && (sx < NCS);
        draw_old = r_draw_vq ? r_draw_q : '0;
        pix_mask = LMS_ROW_W'(1) << py[2:0];
        pix_new  = r_color ? (draw_old | pix_mask) : (draw_old & ~pix_mask);
    end

    // bank address: scan column plus bank offset
    always_comb begin
        baddr    = BAW'(r_scan_col) + BAW'(r_bank) * BAW'(LMS_COLS_PER_BANK);
        baddr_ok = baddr < BAW'(NUM_COLUMNS);
        col_inc  = {1'b0, r_scan_col} + 5'd1;
    end

    // store port control
    always_comb begin
        draw_rd_en   = 1'b0;
        draw_rd_addr = r_idx[AW-1:0];
        draw_wr_en   = 1'b0;
        draw_wr_addr = px[AW-1:0];
        draw_wr_data = pix_new;
        shown_wr_en  = 1'b0;
        unique case (uw.act)
            ACT_PIX_RD: begin
                draw_rd_en   = pix_ok;
                draw_rd_addr = px[AW-1:0];
            end
            ACT_COPY_RD: draw_rd_en = 1'b1;
            ACT_PIX_WR: draw_wr_en = pix_ok;
            ACT_COL_WR: begin
                draw_wr_en   = col_ok;
                draw_wr_addr = sx[AW-1:0];
                draw_wr_data = r_column_value[LMS_ROW_W-1:0];
            end
            ACT_COPY_WR: shown_wr_en = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (draw_wr_en) begin
            r_draw_mem[draw_wr_addr] <= draw_wr_data;
        end
        if (draw_rd_en) begin
            r_draw_q  <= r_draw_mem[draw_rd_addr];
            r_draw_vq <= r_draw_vld[draw_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (shown_wr_en) begin
            r_shown_mem[r_idx[AW-1:0]] <= r_draw_vq ? r_draw_q : '0;
        end
        if (uw.act == ACT_BANK_RD) begin
            r_bank_ok <= baddr_ok;
            if (baddr_ok) begin
                r_shown_q <= r_shown_mem[baddr[AW-1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draw_vld <= '0;
        end else if (uw.act == ACT_CLEAR) begin
            r_draw_vld <= '0;
        end else if (draw_wr_en) begin
            r_draw_vld[draw_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pos_x        <= i_pos_x;
            r_pos_y        <= i_pos_y;
            r_color        <= i_color;
            r_column_value <= i_column_value;
        end
    end

    // next step
    always_comb begin
        take = 1'b0;
        unique case (uw.cond)
            COND_NEXT:      take = 1'b0;
            COND_GOTO:      take = 1'b1;
            COND_DISPATCH:  take = 1'b1;
            COND_NO_COPY:   take = !((r_scan_col == 4'd0) && cfg.auto_update);
            COND_COPY_MORE: take = (r_idx != IW'(NUM_COLUMNS - 1));
            COND_BANK_MORE: take = (r_bank != 2'(LMS_NUM_BANKS - 1));
            COND_INIT_MORE: take = (r_idx != IW'(LMS_INIT_WORDS - 1));
            default:        take = 1'b1;
        endcase
        if (!go) begin
            n_upc = r_upc;
        end else if (uw.cond == COND_DISPATCH) begin
            n_upc = lms_dispatch(i_cmd);
        end else if (take) begin
            n_upc = uw.target;
        end else begin
            n_upc = r_upc + LMS_UPC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc      <= UPC_FETCH;
            r_idx      <= '0;
            r_bank     <= '0;
            r_scan_col <= '0;
            r_shown_ok <= 1'b0;
        end else begin
            r_upc <= n_upc;
            if (go) begin
                unique case (uw.act)
                    ACT_FETCH: begin
                        r_idx  <= '0;
                        r_bank <= '0;
                    end
                    ACT_COPY_WR: begin
                        r_idx <= r_idx + IW'(1);
                        if (r_idx == IW'(NUM_COLUMNS - 1)) begin
                            r_shown_ok <= 1'b1;
                        end
                    end
                    ACT_BANK_EMIT: r_bank <= r_bank + 2'd1;
                    ACT_INIT_EMIT: r_idx <= r_idx + IW'(1);
                    ACT_DIS_EMIT: begin
                        // advance and wrap the scan column
                        r_scan_col <= (col_inc >= 5'(LMS_COLS_PER_BANK)) ? 4'd0 : col_inc[3:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (is_emit && go) begin
                r_o_valid <= 1'b1;
            end
        end
        if (is_emit && go) begin
            r_o_data <= '0;
            r_o_bit  <= '0;
            r_o_val  <= 1'b0;
            r_o_hold <= '0;
            r_o_last <= 1'b0;
            r_o_sel  <= LMS_SEL_LATCH0 + {2'b00, r_scan_col[3]};
            unique case (uw.act)
                ACT_BANK_EMIT: begin
                    r_o_sel  <= LMS_SEL_BANK0 + {1'b0, r_bank};
                    r_o_data <= (r_bank_ok && r_shown_ok) ? r_shown_q : '0;
                end
                ACT_EN_EMIT: begin
                    r_o_bit  <= r_scan_col[2:0];
                    r_o_hold <= cfg.strobe_hold;
                end
                ACT_DIS_EMIT: begin
                    r_o_bit  <= r_scan_col[2:0];
                    r_o_val  <= 1'b1;
                    r_o_last <= 1'b1;
                end
                ACT_INIT_EMIT: begin
                    r_o_sel  <= LMS_SEL_LATCH0 + {2'b00, r_idx[3]};
                    r_o_bit  <= r_idx[2:0];
                    r_o_val  <= 1'b1;
                    r_o_last <= (r_idx == IW'(LMS_INIT_WORDS - 1));
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid       = r_o_valid;
    assign o_select_line = r_o_sel;
    assign o_bank_data   = r_o_data;
    assign o_latch_idx   = r_o_bit;
    assign o_latch_value = r_o_val;
    assign o_hold_ticks  = r_o_hold;
    assign o_last        = r_o_last;

`ifndef ASSERT_OFF
    a_scan_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_scan_col} < 5'(LMS_COLS_PER_BANK))
        else $error("scan column out of range");

    a_last_disables: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_latch_value && o_select_line[2:1] == 2'b11))
        else $error("final word is not a latch disable");

    a_hold_on_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hold_ticks != '0) |-> (!o_latch_value && o_select_line[2:1] == 2'b11))
        else $error("hold ticks on a word other than a latch enable");

    a_emit_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_emit && r_o_valid && !i_ready) |=> $stable(r_upc))
        else $error("step advanced while output word stalled");
`endif

endmodule

FILE: hdl/lms_cfg.sv
// APB configuration registers: rotation, auto update and strobe hold.
module lms_cfg
    import lms_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [LMS_PADDR_W-1:0] paddr,
    input  logic [LMS_PDATA_W-1:0] pwdata,
    output logic [LMS_PDATA_W-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;
    logic wr_en;
    logic [1:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[3:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rotation    <= '0;
            r_cfg.auto_update <= 1'b0;
            r_cfg.strobe_hold <= LMS_STROBE_RESET;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_ROTATION:    r_cfg.rotation    <= pwdata[1:0];
                REG_AUTO_UPDATE: r_cfg.auto_update <= pwdata[0];
                REG_STROBE_HOLD: r_cfg.strobe_hold <= pwdata[LMS_HOLD_W-1:0];
                default: begin
                    // unmapped address: drop the write
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            REG_ROTATION:    prdata = {30'd0, r_cfg.rotation};
            REG_AUTO_UPDATE: prdata = {31'd0, r_cfg.auto_update};
            REG_STROBE_HOLD: prdata = {16'd0, r_cfg.strobe_hold};
            default:         prdata = '0;
        endcase
    end

endmodule

FILE: tb/sv/lms_checker.sv
// Checker for the LED matrix frame scanner: predicts and compares the bus words.
module lms_checker
    import lms_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cmd_valid,
    input  logic                   i_cmd_ready,
    input  logic [2:0]             i_cmd,
    input  logic signed [7:0]      i_pos_x,
    input  logic signed [7:0]      i_pos_y,
    input  logic                   i_color,
    input  logic [7:0]             i_column_value,
    input  logic                   i_word_valid,
    input  logic                   i_word_ready,
    input  logic [2:0]             i_select_line,
    input  logic [LMS_ROW_W-1:0]   i_bank_data,
    input  logic [2:0]             i_latch_idx,
    input  logic                   i_latch_value,
    input  logic [LMS_HOLD_W-1:0]  i_hold_ticks,
    input  logic                   i_last,
    input  logic                   i_psel,
    input  logic                   i_penable,
    input  logic                   i_pwrite,
    input  logic [LMS_PADDR_W-1:0] i_paddr,
    input  logic [LMS_PDATA_W-1:0] i_pwdata,
    input  logic                   i_pready,
    output int                     o_fail_count,
    output int                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]            select_line;
        logic [LMS_ROW_W-1:0]  bank_data;
        logic [2:0]            latch_idx;
        logic                  latch_value;
        logic [LMS_HOLD_W-1:0] hold_ticks;
        logic                  last;
    } t_bus_word;

    t_bus_word            expected_words[$];
    logic [LMS_ROW_W-1:0] draw_img [LMS_NUM_COLUMNS];
    logic [LMS_ROW_W-1:0] shown_img [LMS_NUM_COLUMNS];
    int                   scan_col;
    t_cfg                 cfg;
    int                   fail_total;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        fail_total   = 0;
    end

    task automatic reset_scanner_model();
        for (int i = 0; i < LMS_NUM_COLUMNS; i++) begin
            draw_img[i]  = '0;
            shown_img[i] = '0;
        end
        scan_col        = 0;
        cfg.rotation    = '0;
        cfg.auto_update = 1'b0;
        cfg.strobe_hold = LMS_STROBE_RESET;
    endtask

    task automatic push_word(input int sel, input int data, input int bit_idx,
                             input int val, input int hold, input int last);
        t_bus_word w;
        w.select_line = 3'(sel);
        w.bank_data   = LMS_ROW_W'(data);
        w.latch_idx   = 3'(bit_idx);
        w.latch_value = 1'(val);
        w.hold_ticks  = LMS_HOLD_W'(hold);
        w.last        = 1'(last);
        expected_words.push_back(w);
    endtask

    task automatic plot_pixel(input int x, input int y, input logic color);
        int px, py;
        logic [LMS_ROW_W-1:0] mask;
        px = x;
        py = y;
        // rotate by quarter turns
        case (cfg.rotation)
            2'd1: begin px = LMS_NUM_COLUMNS - y - 1; py = x; end
            2'd2: begin px = LMS_NUM_COLUMNS - x - 1; py = LMS_NUM_ROWS - y - 1; end
            2'd3: begin px = y; py = LMS_NUM_ROWS - x - 1; end
            default: ;
        endcase
        if (px >= 0 && px < LMS_NUM_COLUMNS && py >= 0 && py < LMS_NUM_ROWS) begin
            mask = LMS_ROW_W'(1 << py);
            if (color)
                draw_img[px] = draw_img[px] | mask;
            else
                draw_img[px] = draw_img[px] & ~mask;
        end
    endtask

    task automatic scan_next_column();
        int idx, sel;
        if (scan_col == 0 && cfg.auto_update)
            shown_img = draw_img;
        for (int b = 0; b < LMS_NUM_BANKS; b++) begin
            idx = scan_col + b * LMS_COLS_PER_BANK;
            push_word(LMS_SEL_BANK0 + b, (idx < LMS_NUM_COLUMNS) ? shown_img[idx] : 0,
                      0, 0, 0, 0);
        end
        sel = LMS_SEL_LATCH0 + ((scan_col >> 3) & 1);
        push_word(sel, 0, scan_col & 7, 0, int'(cfg.strobe_hold), 0);
        push_word(sel, 0, scan_col & 7, 1, 0, 1);
        scan_col = scan_col + 1;
        if (scan_col >= LMS_COLS_PER_BANK)
            scan_col = 0;
    endtask

    task automatic predict_command(input logic [2:0] cmd, input int x, input int y,
                                   input logic color, input logic [7:0] colv);
        case (cmd)
            CMD_PIXEL:  plot_pixel(x, y, color);
            CMD_COLUMN: begin
                if (x >= 0 && x < LMS_NUM_COLUMNS)
                    draw_img[x] = colv[LMS_ROW_W-1:0];
            end
            CMD_CLEAR: begin
                for (int i = 0; i < LMS_NUM_COLUMNS; i++)
                    draw_img[i] = '0;
            end
            CMD_SCAN:   scan_next_column();
            CMD_INIT: begin
                for (int l = 0; l < 2; l++)
                    for (int b = 0; b < 8; b++)
                        push_word(LMS_SEL_LATCH0 + l, 0, b, 1, 0,
                                  int'(l == 1 && b == 7));
            end
            default: ;
        endcase
    endtask

    task automatic apply_reg_write(input logic [LMS_PADDR_W-1:0] addr,
                                   input logic [LMS_PDATA_W-1:0] data);
        case (t_reg_idx'(addr[3:2]))
            REG_ROTATION:    cfg.rotation    = data[1:0];
            REG_AUTO_UPDATE: cfg.auto_update = data[0];
            REG_STROBE_HOLD: cfg.strobe_hold = data[LMS_HOLD_W-1:0];
            default: ;
        endcase
    endtask

    function automatic int check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_bus_word got, want;
        int errs;
        if (!i_rst_n) begin
            reset_scanner_model();
            expected_words.delete();
        end else begin
            if (i_word_valid && i_word_ready) begin
                got = '{i_select_line, i_bank_data, i_latch_idx, i_latch_value,
                        i_hold_ticks, i_last};
                if (expected_words.size() == 0) begin
                    $display("%0t ns: unexpected word, expected none, actual 0x%0h",
                             $time, got);
                    fail_total++;
                end else begin
                    want = expected_words.pop_front();
                    errs = check_field("select_line", 16'(want.select_line),
                                       16'(got.select_line))
                         + check_field("bank_data", 16'(want.bank_data), 16'(got.bank_data))
                         + check_field("latch_idx", 16'(want.latch_idx), 16'(got.latch_idx))
                         + check_field("latch_value", 16'(want.latch_value),
                                       16'(got.latch_value))
                         + check_field("hold_ticks", want.hold_ticks, got.hold_ticks)
                         + check_field("last", 16'(want.last), 16'(got.last));
                    if (errs != 0)
                        fail_total++;
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready)
                apply_reg_write(i_paddr, i_pwdata);
            if (i_cmd_valid && i_cmd_ready)
                predict_command(i_cmd, int'(i_pos_x), int'(i_pos_y), i_color,
                                i_column_value);
        end
        o_pending    <= expected_words.size();
        o_fail_count <= fail_total;
    end

endmodule

FILE: tb/sv/tb_top.sv
// Testbench top for the LED matrix frame scanner: stimulus, config writes and verdict.
module tb_top
    import lms_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES     = 200;
    localparam int HOLD_OFF_CYCLES  = 400;
    localparam int NUM_RAND_PHASES  = 5;
    localparam int ITEMS_PER_PHASE  = 18;
    localparam logic [2:0] CMD_FIRST_UNUSED = 3'(CMD_INIT) + 3'd1;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic [2:0]             i_cmd = '0;
    logic signed [7:0]      i_pos_x = '0;
    logic signed [7:0]      i_pos_y = '0;
    logic                   i_color = 1'b0;
    logic [7:0]             i_column_value = '0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic [2:0]             o_select_line;
    logic [LMS_ROW_W-1:0]   o_bank_data;
    logic [2:0]             o_latch_idx;
    logic                   o_latch_value;
    logic [LMS_HOLD_W-1:0]  o_hold_ticks;
    logic                   o_last;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [LMS_PADDR_W-1:0] paddr = '0;
    logic [LMS_PDATA_W-1:0] pwdata = '0;
    logic [LMS_PDATA_W-1:0] prdata;
    logic                   pready;

    int fail_count;
    int pending;
    bit no_idle = 1'b0;
    bit hold_off_req = 1'b0;

    always #5 i_clk = ~i_clk;

    led_matrix_frame_scanner_top dut (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_cmd, .i_pos_x, .i_pos_y, .i_color,
        .i_column_value, .o_valid, .i_ready, .o_select_line, .o_bank_data, .o_latch_idx,
        .o_latch_value, .o_hold_ticks, .o_last, .psel, .penable, .pwrite, .paddr,
        .pwdata, .prdata, .pready
    );

    lms_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (i_valid),
        .i_cmd_ready    (o_ready),
        .i_cmd          (i_cmd),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_color        (i_color),
        .i_column_value (i_column_value),
        .i_word_valid   (o_valid),
        .i_word_ready   (i_ready),
        .i_select_line  (o_select_line),
        .i_bank_data    (o_bank_data),
        .i_latch_idx    (o_latch_idx),
        .i_latch_value  (o_latch_value),
        .i_hold_ticks   (o_hold_ticks),
        .i_last         (o_last),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_pready       (pready),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_cmd(input logic [2:0] cmd, input logic [7:0] x, input logic [7:0] y,
                            input logic color, input logic [7:0] colv);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_cmd          <= cmd;
        i_pos_x        <= x;
        i_pos_y        <= y;
        i_color        <= color;
        i_column_value <= colv;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [LMS_PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LMS_PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // drop valid and wait until every expected word has come
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // idle point for config writes: items with no words may still be in flight
    task automatic settle();
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_random_cmd(input logic [1:0] rot);
        logic [2:0] cmd;
        logic [7:0] x, y, colv;
        logic       color;
        int         r;
        x     = 8'($urandom);
        y     = 8'($urandom);
        colv  = 8'($urandom);
        color = 1'($urandom);
        r     = $urandom_range(0, 99);
        if (r < 35) begin
            cmd = CMD_PIXEL;
            // keep most pixels on the sign for the active rotation
            if ($urandom_range(0, 9) < 8) begin
                if (rot[0]) begin
                    x = 8'($urandom_range(0, LMS_NUM_ROWS - 1));
                    y = 8'($urandom_range(0, LMS_NUM_COLUMNS - 1));
                end else begin
                    x = 8'($urandom_range(0, LMS_NUM_COLUMNS - 1));
                    y = 8'($urandom_range(0, LMS_NUM_ROWS - 1));
                end
            end
        end else if (r < 50) begin
            cmd = CMD_COLUMN;
            if ($urandom_range(0, 9) < 8)
                x = 8'($urandom_range(0, LMS_NUM_COLUMNS - 1));
        end else if (r < 90) begin
            cmd = CMD_SCAN;
        end else if (r < 94) begin
            cmd = CMD_INIT;
        end else if (r < 97) begin
            cmd = CMD_CLEAR;
        end else begin
            cmd = CMD_FIRST_UNUSED + 3'($urandom_range(0, 2));
        end
        send_cmd(cmd, x, y, color, colv);
    endtask

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin
        int stall;
        forever begin
            if (hold_off_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    i_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                i_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        #8_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        logic [1:0] rot;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset config: latches, edge coordinates, off-sign pixels and columns
        send_cmd(CMD_INIT, 8'($urandom), 8'($urandom), 1'b0, 8'($urandom));
        send_cmd(CMD_SCAN, 8'($urandom), 8'($urandom), 1'b1, 8'($urandom));
        send_cmd(CMD_PIXEL, 8'd0, 8'd0, 1'b1, 8'h00);
        send_cmd(CMD_PIXEL, 8'(LMS_NUM_COLUMNS - 1), 8'(LMS_NUM_ROWS - 1), 1'b1, 8'hff);
        send_cmd(CMD_PIXEL, 8'(LMS_NUM_COLUMNS), 8'd0, 1'b1, 8'h00);
        send_cmd(CMD_PIXEL, 8'h80, 8'h7f, 1'b1, 8'h00);
        send_cmd(CMD_PIXEL, 8'h7f, 8'hff, 1'b1, 8'h00);
        send_cmd(CMD_COLUMN, 8'd0, 8'h80, 1'b1, 8'hff);
        send_cmd(CMD_COLUMN, 8'(LMS_NUM_COLUMNS - 1), 8'h7f, 1'b0, 8'h80);
        send_cmd(CMD_COLUMN, 8'(LMS_NUM_COLUMNS), 8'd0, 1'b0, 8'h55);
        send_cmd(CMD_COLUMN, 8'hff, 8'd0, 1'b0, 8'h2a);
        for (int k = 0; k < 3; k++)
            send_cmd(CMD_FIRST_UNUSED + 3'(k), 8'($urandom), 8'($urandom), 1'($urandom),
                     8'($urandom));
        send_cmd(CMD_PIXEL, 8'd0, 8'd0, 1'b0, 8'h00);
        send_cmd(CMD_CLEAR, 8'($urandom), 8'($urandom), 1'b1, 8'($urandom));
        send_cmd(CMD_SCAN, 8'($urandom), 8'($urandom), 1'b0, 8'($urandom));

        // each non-zero rotation with edge pixels, zero and full hold
        for (int q = 1; q < 4; q++) begin
            settle();
            write_reg(REG_ROTATION, 32'(q));
            write_reg(REG_AUTO_UPDATE, 1);
            write_reg(REG_STROBE_HOLD, (q == 1) ? 0 : (q == 2) ? 32'hffff : 1);
            send_cmd(CMD_PIXEL, 8'd0, 8'd0, 1'b1, 8'h00);
            send_cmd(CMD_PIXEL, 8'(LMS_NUM_ROWS - 1), 8'(LMS_NUM_COLUMNS - 1), 1'b1, 8'h00);
            send_cmd(CMD_PIXEL, 8'(LMS_NUM_ROWS), 8'(LMS_NUM_COLUMNS), 1'b1, 8'h00);
            send_cmd(CMD_SCAN, 8'($urandom), 8'($urandom), 1'b1, 8'($urandom));
        end

        for (int ph = 0; ph < NUM_RAND_PHASES; ph++) begin
            settle();
            rot = (ph < 4) ? 2'(ph) : 2'($urandom_range(0, 3));
            write_reg(REG_ROTATION, 32'(rot));
            write_reg(REG_AUTO_UPDATE, (ph == 1) ? 0 : (ph == 4) ? $urandom_range(0, 1) : 1);
            case (ph)
                0:       write_reg(REG_STROBE_HOLD, 1);
                1:       write_reg(REG_STROBE_HOLD, 32'hffff);
                2:       write_reg(REG_STROBE_HOLD, 0);
                default: write_reg(REG_STROBE_HOLD, $urandom_range(1, 65535));
            endcase
            no_idle = (ph == 3);
            if (ph == 1)
                hold_off_req = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == 2 && n == ITEMS_PER_PHASE / 2)
                    drain_results();
                send_random_cmd(rot);
            end
        end
        no_idle = 1'b0;

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
